>>> hw/rtl/sni_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sni_pkg
// shared widths, codes, state type and control structs of the subnet indexer
// ----------------------------------------------------------------------------
package sni_pkg;

    localparam int ADDR_W       = 32;
    localparam int NET_INDEX_W  = 10;
    localparam int STATUS_W     = 2;
    localparam logic [ADDR_W-1:0] MASK_RESET = 32'hFFFF_FF00;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_ADDED     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_FULL      = 2'd3
    } t_net_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_SLOT,
        S_CHECK_SLOT,
        S_CHECK_KEY,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic        clear_wr;
        logic        accept;
        logic        insert;
        logic        advance;
        logic        set_res;
        t_net_status res_code;
        logic        load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic in_malformed;
        logic slot_empty;
        logic key_match;
        logic table_full;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/sni_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sni_in_if
// input channel: client address and malformed flag
// ----------------------------------------------------------------------------
interface sni_in_if
    import sni_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] client_address;
    logic              is_malformed;

    modport source (output valid, output client_address, output is_malformed, input ready);
    modport sink   (input valid, input client_address, input is_malformed, output ready);
endinterface

>>> hw/rtl/sni_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sni_out_if
// result channel: dense network index and status
// ----------------------------------------------------------------------------
interface sni_out_if
    import sni_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [NET_INDEX_W-1:0] net_index;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output net_index, output status, input ready);
    modport sink   (input valid, input net_index, input status, output ready);
endinterface

>>> hw/rtl/subnet_first_seen_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subnet_first_seen_indexer
// masks client addresses and maps each network to a dense first-seen index
// a malformed address goes straight to the result; others probe from the hashed
// slot past occupied slots to the matching or the free slot
// one transaction at a time: a new address is taken only once the previous
// result is loaded for output; the hash probe loop uses the slot memory and network store read ports
// reset: clears entry count and output, restores mask 255.255.255.0, then a
// slot clearing pass over all hash slots before input is taken
// ----------------------------------------------------------------------------
module subnet_first_seen_indexer
    import sni_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    sni_in_if.sink            i_in,
    sni_out_if.source         o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    sni_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    sni_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_client_address (i_in.client_address),
        .i_is_malformed   (i_in.is_malformed),
        .i_out_ready      (o_out.ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out.valid),
        .o_net_index      (o_out.net_index),
        .o_status         (o_out.status)
    );

endmodule

>>> hw/rtl/sni_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sni_ctrl
// sequencer for slot clearing, hash probing, insertion and result hand-off
// ----------------------------------------------------------------------------
module sni_ctrl
    import sni_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_malformed ? S_RESULT : S_READ_SLOT;
                end
            end
            S_READ_SLOT: begin
                n_state = S_CHECK_SLOT;
            end
            S_CHECK_SLOT: begin
                n_state = i_stat.slot_empty ? S_RESULT : S_CHECK_KEY;
            end
            S_CHECK_KEY: begin
                n_state = i_stat.key_match ? S_RESULT : S_READ_SLOT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_malformed) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_MALFORMED;
                    end
                end
            end
            S_CHECK_SLOT: begin
                if (i_stat.slot_empty) begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.table_full) begin
                        o_cmd.res_code = ST_FULL;
                    end else begin
                        o_cmd.res_code = ST_ADDED;
                        o_cmd.insert   = 1'b1;
                    end
                end
            end
            S_CHECK_KEY: begin
                if (i_stat.key_match) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FOUND;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_RESULT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/sni_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sni_datapath
// mask register, hash slot memory, network store, entry count, result register
// ----------------------------------------------------------------------------
module sni_datapath
    import sni_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [ADDR_W-1:0]      i_cfg_wdata,
    input  logic [ADDR_W-1:0]      i_client_address,
    input  logic                   i_is_malformed,
    input  logic                   i_out_ready,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    output logic [NET_INDEX_W-1:0] o_net_index,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int SW     = $clog2(CAPACITY + 1);
    localparam int HB     = $clog2(CAPACITY) + 1;
    localparam int HSLOTS = 1 << HB;
    localparam int NCH    = (ADDR_W + HB - 1) / HB;

    function automatic logic [HB-1:0] f_hash(input logic [ADDR_W-1:0] v);
        logic [HB*NCH-1:0] padded;
        logic [HB-1:0]     h;
        padded = (HB*NCH)'(v);
        h      = '0;
        for (int k = 0; k < NCH; k++) begin
            h = h ^ padded[k*HB +: HB];
        end
        return h;
    endfunction

    logic [SW-1:0]     slot_mem [HSLOTS];
    logic [ADDR_W-1:0] net_mem  [CAPACITY];

    logic [ADDR_W-1:0] r_mask;
    logic [ADDR_W-1:0] r_net;
    logic [HB-1:0]     r_ptr;
    logic [HB-1:0]     r_clr_cnt;
    logic [SW-1:0]     r_count;
    logic [SW-1:0]     r_slot_q;
    logic [ADDR_W-1:0] r_key_q;
    logic [IW-1:0]     r_res_idx;
    t_net_status       r_res_st;
    logic              r_out_valid;
    logic [IW-1:0]     r_out_idx;
    t_net_status       r_out_st;

    logic [ADDR_W-1:0] w_masked;
    logic [SW-1:0]     w_slot_m1;
    logic [HB-1:0]     w_wr_addr;
    logic [SW-1:0]     w_wr_data;
    logic              w_wr_en;
    logic [IW+NET_INDEX_W-1:0] w_idx_ext;

    assign w_masked  = i_client_address & r_mask;
    assign w_slot_m1 = r_slot_q - SW'(1);
    assign w_wr_en   = i_cmd.clear_wr | i_cmd.insert;
    assign w_wr_addr = i_cmd.clear_wr ? r_clr_cnt : r_ptr;
    assign w_wr_data = i_cmd.clear_wr ? '0 : r_count + SW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            slot_mem[w_wr_addr] <= w_wr_data;
        end
        r_slot_q <= slot_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            net_mem[r_count[IW-1:0]] <= r_net;
        end
        r_key_q <= net_mem[w_slot_m1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_cnt <= r_clr_cnt + HB'(1);
            end
            if (i_cmd.insert) begin
                r_count <= r_count + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_net <= w_masked;
            r_ptr <= f_hash(w_masked);
        end else if (i_cmd.advance) begin
            r_ptr <= r_ptr + HB'(1);
        end
        if (i_cmd.set_res) begin
            r_res_st <= i_cmd.res_code;
            case (i_cmd.res_code)
                ST_FOUND: r_res_idx <= w_slot_m1[IW-1:0];
                ST_ADDED: r_res_idx <= r_count[IW-1:0];
                default:  r_res_idx <= '0;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_idx <= r_res_idx;
            r_out_st  <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.clear_done   = (r_clr_cnt == HB'(HSLOTS - 1));
    assign o_stat.in_malformed = i_is_malformed;
    assign o_stat.slot_empty   = (r_slot_q == '0);
    assign o_stat.key_match    = (r_key_q == r_net);
    assign o_stat.table_full   = (r_count == SW'(CAPACITY));
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign w_idx_ext   = {{NET_INDEX_W{1'b0}}, r_out_idx};
    assign o_out_valid = r_out_valid;
    assign o_net_index = w_idx_ext[NET_INDEX_W-1:0];
    assign o_status    = r_out_st;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !o_stat.table_full && o_stat.slot_empty)
        else $error("insert into full table or occupied slot");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_count == $past(r_count) + SW'(1))
        else $error("entry count did not advance on insert");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before it was taken");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives client addresses through subnet_first_seen_indexer under several
// netmasks, fills the network table to capacity, and checks each result
// transaction field by field against a fixed expectation or a built-in network index predictor
// ----------------------------------------------------------------------------
module testbench
    import sni_pkg::*;
();

    localparam int CAPACITY     = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 6;
    localparam int TAIL_CYCLES  = 40;
    localparam int RUN_LIMIT_NS = 20_000_000;

    typedef struct packed {
        logic [NET_INDEX_W-1:0] net_index;
        t_net_status            status;
    } t_net_result;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic              malformed;
        bit                fixed;
        t_net_result       result;
    } t_stim_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;

    sni_in_if  in_bus ();
    sni_out_if out_bus ();

    subnet_first_seen_indexer #(.CAPACITY(CAPACITY)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // predictor state
    logic [ADDR_W-1:0] mask_q = MASK_RESET;
    int unsigned       network_ids [bit [ADDR_W-1:0]];
    int unsigned       network_count = 0;
    t_net_result       pending_results [$];
    logic [ADDR_W-1:0] recent_addresses [$];

    int unsigned errors       = 0;
    int unsigned hold_left    = 0;
    bit          quiet        = 1'b0;
    bit          hold_request = 1'b0;

    // mask 255.255.255.0, empty table
    t_stim_row directed_rows [19] = '{
        '{32'h0A00_0001, 1'b1, 1'b1, '{10'd0, ST_MALFORMED}},
        '{32'h0A00_0001, 1'b0, 1'b1, '{10'd0, ST_ADDED}},
        '{32'h0A00_00FE, 1'b0, 1'b1, '{10'd0, ST_FOUND}},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, '{10'd1, ST_ADDED}},
        '{32'h0000_0000, 1'b0, 1'b1, '{10'd2, ST_ADDED}},
        '{32'hFFFF_FF00, 1'b0, 1'b1, '{10'd1, ST_FOUND}},
        '{32'h0000_00FF, 1'b0, 1'b1, '{10'd2, ST_FOUND}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{10'd0, ST_MALFORMED}},
        '{32'hC0A8_0101, 1'b1, 1'b1, '{10'd0, ST_MALFORMED}},
        '{32'hC0A8_0164, 1'b0, 1'b1, '{10'd3, ST_ADDED}},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h5555_5555, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h0A00_0101, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h8000_0000, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h0000_0100, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h5555_5500, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'hC0A8_01FF, 1'b0, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, '{10'd0, ST_FOUND}},
        '{32'h0A00_0137, 1'b0, 1'b0, '{10'd0, ST_FOUND}}
    };

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_net_result index_network(logic [ADDR_W-1:0] address,
                                                  logic malformed);
        t_net_result       res;
        bit [ADDR_W-1:0]   net;
        res.net_index = '0;
        res.status    = ST_MALFORMED;
        if (!malformed) begin
            net = address & mask_q;
            if (network_ids.exists(net)) begin
                res.net_index = NET_INDEX_W'(network_ids[net]);
                res.status    = ST_FOUND;
            end else if (network_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                network_ids[net] = network_count;
                res.net_index    = NET_INDEX_W'(network_count);
                res.status       = ST_ADDED;
                network_count++;
            end
        end
        return res;
    endfunction

    task automatic send_client(logic [ADDR_W-1:0] address, logic malformed, bit fixed,
                               t_net_result fixed_result);
        t_net_result predicted;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_bus.valid = 1'b0;
            @(negedge clk);
        end
        in_bus.valid          = 1'b1;
        in_bus.client_address = address;
        in_bus.is_malformed   = malformed;
        do @(posedge clk); while (!in_bus.ready);
        predicted = index_network(address, malformed);
        pending_results.push_back(fixed ? fixed_result : predicted);
        recent_addresses.push_back(address);
        if (recent_addresses.size() > 64)
            void'(recent_addresses.pop_front());
    endtask

    task automatic send_random(int unsigned reuse_pct);
        logic [ADDR_W-1:0] address;
        address = $urandom;
        if (recent_addresses.size() > 0 && $urandom_range(0, 99) < reuse_pct)
            address = recent_addresses[$urandom_range(0, recent_addresses.size() - 1)]
                      ^ ($urandom & ~mask_q);
        send_client(address, $urandom_range(0, 99) < 5, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        in_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mask(logic [ADDR_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        mask_q = value;
    endtask

    // receiver: long hold on request, otherwise random stalls unless quiet
    always @(negedge clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            out_bus.ready = 1'b0;
            hold_left--;
        end else begin
            out_bus.ready = quiet || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // result transaction checker
    always @(posedge clk) begin
        t_net_result expected;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result: index %0d status %0d",
                             $realtime, out_bus.net_index, out_bus.status);
            end else begin
                expected = pending_results.pop_front();
                if (out_bus.net_index !== expected.net_index ||
                    out_bus.status !== expected.status) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t mismatch: expected index %0d status %0d, got %0d %0d",
                                 $realtime, expected.net_index, expected.status,
                                 out_bus.net_index, out_bus.status);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned items;
        int unsigned after_full;
        in_bus.valid          = 1'b0;
        in_bus.client_address = '0;
        in_bus.is_malformed   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_client(directed_rows[i].address, directed_rows[i].malformed,
                        directed_rows[i].fixed, directed_rows[i].result);

        // wider networks, first half with no idling
        write_mask(32'hFFFF_0000);
        quiet = 1'b1;
        repeat (60) send_random(50);
        quiet = 1'b0;
        repeat (60) send_random(50);

        // every address maps to network zero
        write_mask(32'h0000_0000);
        repeat (20) send_random(20);

        // host masks: fill the table, then run past full
        write_mask(32'hFFFF_FFFF);
        items      = 0;
        after_full = 0;
        while (network_count < CAPACITY || after_full < 50) begin
            if (items == 150)
                hold_request = 1'b1;
            if (items == 500)
                drain();
            send_random(network_count < CAPACITY ? 10 : 50);
            if (network_count >= CAPACITY)
                after_full++;
            items++;
        end

        write_mask($urandom);
        repeat (40) send_random(60);

        write_mask(32'hFFFF_FFFF << $urandom_range(1, 31));
        repeat (40) send_random(60);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
